// ===== design/bcdlm_pkg.sv =====
package bcdlm_pkg;

   // Block lengths and the four-cell debounce limit.
   localparam int DETECT_SAMPLES   = 21;
   localparam int MONITOR_SAMPLES  = 67;
   localparam int LOW_STREAK_LIMIT = 40;

   // Field and state widths.
   localparam int CODE_W    = 12;
   localparam int SCALE_W   = 16;
   localparam int PROTECT_W = 10;
   localparam int MV_W      = 16;
   localparam int SUM_W     = 22;
   localparam int COUNT_W   = 7;
   localparam int STREAK_W  = 6;
   localparam int PACK_W    = 2;
   localparam int PROD_W    = CODE_W + SCALE_W;

   localparam logic [MV_W-1:0]     MV_MAX     = '1;
   localparam logic [SUM_W-1:0]    SUM_MAX    = '1;
   localparam logic [STREAK_W-1:0] STREAK_MAX = '1;

   // Microvolts to millivolts: floor(p / 1000) as (p * MV_RECIP) >> MV_DIV_SHIFT.
   // The shift is the product width plus ten, which makes the result exact.
   localparam int MV_DIV_SHIFT = PROD_W + 10;
   localparam int MV_RECIP_W   = PROD_W + 1;
   localparam longint unsigned MV_RECIP_L =
      ((64'd1 << MV_DIV_SHIFT) + 64'd999) / 64'd1000;
   localparam logic [MV_RECIP_W-1:0] MV_RECIP = MV_RECIP_W'(MV_RECIP_L);
   localparam int MV_Q_W = PROD_W + MV_RECIP_W - MV_DIV_SHIFT;

   // Block average: floor(sum / N) as (sum * recip) >> AVG_DIV_SHIFT.
   // With the shift at SUM_W + COUNT_W the quotient is exact for any N up to 127.
   localparam int AVG_DIV_SHIFT = SUM_W + COUNT_W;
   localparam int AVG_RECIP_W   = AVG_DIV_SHIFT + 1;
   localparam longint unsigned DET_RECIP_L =
      ((64'd1 << AVG_DIV_SHIFT) + 64'(DETECT_SAMPLES) - 64'd1) / 64'(DETECT_SAMPLES);
   localparam longint unsigned MON_RECIP_L =
      ((64'd1 << AVG_DIV_SHIFT) + 64'(MONITOR_SAMPLES) - 64'd1) / 64'(MONITOR_SAMPLES);
   localparam logic [AVG_RECIP_W-1:0] DET_RECIP = AVG_RECIP_W'(DET_RECIP_L);
   localparam logic [AVG_RECIP_W-1:0] MON_RECIP = AVG_RECIP_W'(MON_RECIP_L);
   localparam int AVG_Q_W = SUM_W + AVG_RECIP_W - AVG_DIV_SHIFT;

   // Pack type codes.
   localparam logic [PACK_W-1:0] PACK_UNKNOWN = 2'd0;
   localparam logic [PACK_W-1:0] PACK_3S      = 2'd1;
   localparam logic [PACK_W-1:0] PACK_4S      = 2'd2;

   // Classification windows in millivolts, both ends exclusive.
   localparam logic [MV_W-1:0] PACK_3S_LO_MV = 16'd10100;
   localparam logic [MV_W-1:0] PACK_3S_HI_MV = 16'd13600;
   localparam logic [MV_W-1:0] PACK_4S_LO_MV = 16'd13800;
   localparam logic [MV_W-1:0] PACK_4S_HI_MV = 16'd17400;

   // Low-battery thresholds before the protect term, in millivolts.
   localparam logic [MV_W-1:0] THR_3S_BASE_MV = 16'd10500;
   localparam logic [MV_W-1:0] THR_4S_BASE_MV = 16'd14200;

   // floor(x / 5) for x below 2**13 as (x * DIV5_RECIP) >> DIV5_SHIFT.
   localparam int DIV5_X_W   = PROTECT_W + 3;
   localparam int DIV5_SHIFT = DIV5_X_W + 3;
   localparam logic [DIV5_X_W:0] DIV5_RECIP = 14'd13108;

   // Configuration registers.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = SCALE_W;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_IDX   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROTECT_IDX = 1'd1;
   localparam logic [SCALE_W-1:0]   SCALE_RESET     = 16'd9036;

   typedef struct packed {
      logic [SCALE_W-1:0] scale;
      logic [MV_W-1:0]    thr_3s_mv;
      logic [MV_W-1:0]    thr_4s_mv;
   } cfg_type;

   typedef struct packed {
      logic            is_block;
      logic            monitor;
      logic            done;
      logic [MV_W-1:0] avg;
   } blk_type;

endpackage

// ===== design/bcdlm_if.sv =====
interface bcdlm_req_if;
   logic                           valid;
   logic                           ready;
   logic [bcdlm_pkg::CODE_W-1:0]   adc_code;

   modport source (output valid, output adc_code, input ready);
   modport sink (input valid, input adc_code, output ready);
endinterface

interface bcdlm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bcdlm_pkg::PACK_W-1:0]   cell_config;
   logic                           detect_done;
   logic                           low_battery;
   logic [bcdlm_pkg::MV_W-1:0]     average_mv;

   modport source (output valid, output cell_config, output detect_done,
                   output low_battery, output average_mv, input ready);
   modport sink (input valid, input cell_config, input detect_done,
                 input low_battery, input average_mv, output ready);
endinterface

interface bcdlm_csr_if;
   logic                              valid;
   logic                              ready;
   logic [bcdlm_pkg::CSR_IDX_W-1:0]   index;
   logic [bcdlm_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/bcdlm_csr.sv =====
module bcdlm_csr (
   input  logic               clock,
   input  logic               reset,
   bcdlm_csr_if.sink          csr_bus,
   output bcdlm_pkg::cfg_type cfg
);

   logic [bcdlm_pkg::SCALE_W-1:0]   scale_ff;
   logic [bcdlm_pkg::PROTECT_W-1:0] protect_ff;
   logic [bcdlm_pkg::MV_W-1:0]      thr_3s_ff, thr_3s_in;
   logic [bcdlm_pkg::MV_W-1:0]      thr_4s_ff, thr_4s_in;
   logic [bcdlm_pkg::PROTECT_W+1:0] half_num;
   logic [bcdlm_pkg::DIV5_X_W-1:0]  fifth_num;
   logic [bcdlm_pkg::DIV5_X_W+bcdlm_pkg::DIV5_X_W:0] fifth_prod;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff   <= bcdlm_pkg::SCALE_RESET;
         protect_ff <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            bcdlm_pkg::CSR_SCALE_IDX: scale_ff <= csr_bus.data;
            bcdlm_pkg::CSR_PROTECT_IDX: protect_ff <= csr_bus.data[bcdlm_pkg::PROTECT_W-1:0];
            default: ;
         endcase
      end
   end

   // The thresholds are ceil(base + 1.5 * p) and ceil(base + 1.6 * p) in
   // millivolts, so an integer average compares against them exactly.
   always_comb begin
      half_num   = (bcdlm_pkg::PROTECT_W+2)'(protect_ff) *
                   (bcdlm_pkg::PROTECT_W+2)'(3) + 1'b1;
      fifth_num  = {protect_ff, 3'b100};
      fifth_prod = (2*bcdlm_pkg::DIV5_X_W+1)'(fifth_num) *
                   (2*bcdlm_pkg::DIV5_X_W+1)'(bcdlm_pkg::DIV5_RECIP);
      thr_3s_in  = bcdlm_pkg::THR_3S_BASE_MV + bcdlm_pkg::MV_W'(half_num[bcdlm_pkg::PROTECT_W+1:1]);
      thr_4s_in  = bcdlm_pkg::THR_4S_BASE_MV +
                   bcdlm_pkg::MV_W'(fifth_prod[2*bcdlm_pkg::DIV5_X_W:bcdlm_pkg::DIV5_SHIFT]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_3s_ff <= bcdlm_pkg::THR_3S_BASE_MV;
         thr_4s_ff <= bcdlm_pkg::THR_4S_BASE_MV;
      end else begin
         thr_3s_ff <= thr_3s_in;
         thr_4s_ff <= thr_4s_in;
      end
   end

   assign cfg.scale     = scale_ff;
   assign cfg.thr_3s_mv = thr_3s_ff;
   assign cfg.thr_4s_mv = thr_4s_ff;

endmodule

// ===== design/bcdlm_scale.sv =====
module bcdlm_scale (
   input  logic                          clock,
   input  logic                          reset,
   bcdlm_req_if.sink                     req_bus,
   input  logic [bcdlm_pkg::SCALE_W-1:0] scale,
   output logic                          mv_valid,
   input  logic                          mv_ready,
   output logic                          mv_nonzero,
   output logic [bcdlm_pkg::MV_W-1:0]    mv_value
);

   logic                                 v1_ff, v2_ff, v3_ff;
   logic                                 rdy1, rdy2, rdy3;
   logic [bcdlm_pkg::CODE_W-1:0]         code1_ff;
   logic [bcdlm_pkg::PROD_W-1:0]         prod2_ff, prod2_in;
   logic                                 nz2_ff, nz3_ff;
   logic [bcdlm_pkg::MV_W-1:0]           mv3_ff, mv3_in;
   logic [bcdlm_pkg::PROD_W+bcdlm_pkg::MV_RECIP_W-1:0] div_prod;
   logic [bcdlm_pkg::MV_Q_W-1:0]         div_q;

   // Each stage takes a word when it is empty or its word moves on.
   assign rdy3          = !v3_ff || mv_ready;
   assign rdy2          = !v2_ff || rdy3;
   assign rdy1          = !v1_ff || rdy2;
   assign req_bus.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_bus.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   assign prod2_in = bcdlm_pkg::PROD_W'(code1_ff) * bcdlm_pkg::PROD_W'(scale);

   always_comb begin
      div_prod = (bcdlm_pkg::PROD_W+bcdlm_pkg::MV_RECIP_W)'(prod2_ff) *
                 (bcdlm_pkg::PROD_W+bcdlm_pkg::MV_RECIP_W)'(bcdlm_pkg::MV_RECIP);
      div_q    = div_prod[bcdlm_pkg::PROD_W+bcdlm_pkg::MV_RECIP_W-1:bcdlm_pkg::MV_DIV_SHIFT];
      if (div_q > bcdlm_pkg::MV_Q_W'(bcdlm_pkg::MV_MAX)) begin
         mv3_in = bcdlm_pkg::MV_MAX;
      end else begin
         mv3_in = div_q[bcdlm_pkg::MV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_bus.valid) begin
         code1_ff <= req_bus.adc_code;
      end
      if (rdy2 && v1_ff) begin
         prod2_ff <= prod2_in;
         nz2_ff   <= (code1_ff != '0);
      end
      if (rdy3 && v2_ff) begin
         mv3_ff <= mv3_in;
         nz3_ff <= nz2_ff;
      end
   end

   assign mv_valid   = v3_ff;
   assign mv_nonzero = nz3_ff;
   assign mv_value   = mv3_ff;

endmodule

// ===== design/bcdlm_accum.sv =====
module bcdlm_accum (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       mv_valid,
   output logic                       mv_ready,
   input  logic                       mv_nonzero,
   input  logic [bcdlm_pkg::MV_W-1:0] mv_value,
   output logic                       blk_valid,
   input  logic                       blk_ready,
   output bcdlm_pkg::blk_type         blk
);

   logic                                  phase_ff, phase_in;
   logic [bcdlm_pkg::SUM_W-1:0]           sum_ff, sum_in;
   logic [bcdlm_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic [bcdlm_pkg::SUM_W:0]             sum_wide;
   logic [bcdlm_pkg::SUM_W-1:0]           total;
   logic [bcdlm_pkg::COUNT_W-1:0]         count_next;
   logic [bcdlm_pkg::COUNT_W-1:0]         block_len;
   logic                                  is_block;

   logic                                  v4_ff, v5_ff, rdy4, rdy5, load4;
   logic [bcdlm_pkg::SUM_W-1:0]           total4_ff;
   logic                                  blk4_ff, mon4_ff, done4_ff;
   logic [bcdlm_pkg::AVG_RECIP_W-1:0]     recip;
   logic [bcdlm_pkg::SUM_W+bcdlm_pkg::AVG_RECIP_W-1:0] avg_prod;
   logic [bcdlm_pkg::AVG_Q_W-1:0]         avg_q;
   logic [bcdlm_pkg::MV_W-1:0]            avg5_in;
   bcdlm_pkg::blk_type                    blk5_ff;

   assign rdy5     = !v5_ff || blk_ready;
   assign rdy4     = !v4_ff || rdy5;
   assign mv_ready = rdy4;
   assign load4    = mv_valid && rdy4;

   always_comb begin
      sum_wide   = (bcdlm_pkg::SUM_W+1)'(sum_ff) + (bcdlm_pkg::SUM_W+1)'(mv_value);
      total      = sum_wide[bcdlm_pkg::SUM_W] ? bcdlm_pkg::SUM_MAX : sum_wide[bcdlm_pkg::SUM_W-1:0];
      count_next = count_ff + 1'b1;
      block_len  = phase_ff ? bcdlm_pkg::COUNT_W'(bcdlm_pkg::MONITOR_SAMPLES)
                            : bcdlm_pkg::COUNT_W'(bcdlm_pkg::DETECT_SAMPLES);
      is_block   = mv_nonzero && (count_next == block_len);
      sum_in     = sum_ff;
      count_in   = count_ff;
      phase_in   = phase_ff;
      if (mv_nonzero) begin
         if (is_block) begin
            sum_in   = '0;
            count_in = '0;
            phase_in = 1'b1;
         end else begin
            sum_in   = total;
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         sum_ff   <= '0;
         count_ff <= '0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
      end else begin
         if (load4) begin
            phase_ff <= phase_in;
            sum_ff   <= sum_in;
            count_ff <= count_in;
         end
         if (rdy4) v4_ff <= mv_valid;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load4) begin
         total4_ff <= total;
         blk4_ff   <= is_block;
         mon4_ff   <= phase_ff;
         done4_ff  <= phase_in;
      end
      if (rdy5 && v4_ff) begin
         blk5_ff.is_block <= blk4_ff;
         blk5_ff.monitor  <= mon4_ff;
         blk5_ff.done     <= done4_ff;
         blk5_ff.avg      <= avg5_in;
      end
   end

   // The block total is divided by the block length that was in force for it.
   always_comb begin
      recip    = mon4_ff ? bcdlm_pkg::MON_RECIP : bcdlm_pkg::DET_RECIP;
      avg_prod = (bcdlm_pkg::SUM_W+bcdlm_pkg::AVG_RECIP_W)'(total4_ff) *
                 (bcdlm_pkg::SUM_W+bcdlm_pkg::AVG_RECIP_W)'(recip);
      avg_q    = avg_prod[bcdlm_pkg::SUM_W+bcdlm_pkg::AVG_RECIP_W-1:bcdlm_pkg::AVG_DIV_SHIFT];
      if (avg_q > bcdlm_pkg::AVG_Q_W'(bcdlm_pkg::MV_MAX)) begin
         avg5_in = bcdlm_pkg::MV_MAX;
      end else begin
         avg5_in = avg_q[bcdlm_pkg::MV_W-1:0];
      end
   end

   assign blk_valid = v5_ff;
   assign blk       = blk5_ff;

endmodule

// ===== design/bcdlm_eval.sv =====
module bcdlm_eval (
   input  logic               clock,
   input  logic               reset,
   input  bcdlm_pkg::cfg_type cfg,
   input  logic               blk_valid,
   output logic               blk_ready,
   input  bcdlm_pkg::blk_type blk,
   bcdlm_rsp_if.source        rsp_bus
);

   logic                              out_valid_ff;
   logic                              load;
   logic [bcdlm_pkg::PACK_W-1:0]      pack_ff, pack_in;
   logic                              done_ff;
   logic                              low_ff, low_in;
   logic [bcdlm_pkg::MV_W-1:0]        avg_ff, avg_in;
   logic [bcdlm_pkg::STREAK_W-1:0]    streak_ff, streak_in;

   assign blk_ready = !out_valid_ff || rsp_bus.ready;
   assign load      = blk_valid && blk_ready;

   always_comb begin
      pack_in   = pack_ff;
      low_in    = low_ff;
      avg_in    = avg_ff;
      streak_in = streak_ff;
      if (blk.is_block) begin
         avg_in = blk.avg;
         if (!blk.monitor) begin
            if (blk.avg > bcdlm_pkg::PACK_3S_LO_MV && blk.avg < bcdlm_pkg::PACK_3S_HI_MV) begin
               pack_in = bcdlm_pkg::PACK_3S;
            end else if (blk.avg > bcdlm_pkg::PACK_4S_LO_MV &&
                         blk.avg < bcdlm_pkg::PACK_4S_HI_MV) begin
               pack_in = bcdlm_pkg::PACK_4S;
            end else begin
               pack_in = bcdlm_pkg::PACK_UNKNOWN;
            end
         end else begin
            case (pack_ff)
               bcdlm_pkg::PACK_3S: begin
                  low_in = (blk.avg < cfg.thr_3s_mv);
               end
               bcdlm_pkg::PACK_4S: begin
                  // A four-cell pack must read low for a run of blocks first.
                  if (blk.avg < cfg.thr_4s_mv) begin
                     if (streak_ff != bcdlm_pkg::STREAK_MAX) begin
                        streak_in = streak_ff + 1'b1;
                     end
                  end else begin
                     streak_in = '0;
                  end
                  low_in = (streak_in > bcdlm_pkg::STREAK_W'(bcdlm_pkg::LOW_STREAK_LIMIT));
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pack_ff      <= bcdlm_pkg::PACK_UNKNOWN;
         done_ff      <= 1'b0;
         low_ff       <= 1'b0;
         avg_ff       <= '0;
         streak_ff    <= '0;
      end else begin
         if (blk_ready) out_valid_ff <= blk_valid;
         if (load) begin
            pack_ff   <= pack_in;
            done_ff   <= blk.done;
            low_ff    <= low_in;
            avg_ff    <= avg_in;
            streak_ff <= streak_in;
         end
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.cell_config = pack_ff;
   assign rsp_bus.detect_done = done_ff;
   assign rsp_bus.low_battery = low_ff;
   assign rsp_bus.average_mv  = avg_ff;

   a_done_sticky: assert property (@(posedge clock) disable iff (reset) !$fell(done_ff))
      else $error("detect_done dropped without reset");

   a_low_after_detect: assert property (@(posedge clock) disable iff (reset)
      low_ff |-> (done_ff && pack_ff != bcdlm_pkg::PACK_UNKNOWN))
      else $error("low battery flagged before a known pack type");

   a_pack_frozen: assert property (@(posedge clock) disable iff (reset)
      (done_ff && $past(done_ff)) |-> $stable(pack_ff))
      else $error("pack type changed during monitoring");

   a_streak_only_4s: assert property (@(posedge clock) disable iff (reset)
      (streak_ff != '0) |-> (pack_ff == bcdlm_pkg::PACK_4S))
      else $error("low streak counted for a pack that is not four-cell");

endmodule

// ===== design/battery_cell_detect_low_monitor_core.sv =====
// Battery pack cell-count detector and low-battery monitor.
//
// req_bus carries one 12-bit ADC code per word. Every accepted word gives one
// word on rsp_bus with the pack type, the detect-done flag, the low-battery flag
// and the latest block average in millivolts. Codes of zero leave the state as
// it is and just report it.
// csr_bus writes index 0 (scale, microvolts per count) and index 1 (protect
// fraction in thousandths); it is always ready. Write it only while the
// pipeline is empty; the threshold registers follow the stored fraction.
//
// One word is taken per cycle while rsp_bus is ready. The path is six
// register stages: input, scale multiply, divide by 1000, accumulate, block
// average, and the result register, which also holds the pack state. Each
// stage loads whenever it is empty or its word moves on, so a stalled
// receiver backs words up stage by stage and req_bus keeps taking words
// until all six stages are full.
// Synchronous reset empties the pipeline, returns to the detect phase and
// restores the configuration to its reset values.
module battery_cell_detect_low_monitor_core (
   input  logic        clock,
   input  logic        reset,
   bcdlm_req_if.sink   req_bus,
   bcdlm_rsp_if.source rsp_bus,
   bcdlm_csr_if.sink   csr_bus
);

   bcdlm_pkg::cfg_type             cfg;
   logic                           mv_valid, mv_ready, mv_nonzero;
   logic [bcdlm_pkg::MV_W-1:0]     mv_value;
   logic                           blk_valid, blk_ready;
   bcdlm_pkg::blk_type             blk;

   bcdlm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   bcdlm_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .scale      (cfg.scale),
      .mv_valid   (mv_valid),
      .mv_ready   (mv_ready),
      .mv_nonzero (mv_nonzero),
      .mv_value   (mv_value)
   );

   bcdlm_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .mv_valid   (mv_valid),
      .mv_ready   (mv_ready),
      .mv_nonzero (mv_nonzero),
      .mv_value   (mv_value),
      .blk_valid  (blk_valid),
      .blk_ready  (blk_ready),
      .blk        (blk)
   );

   bcdlm_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .blk_valid (blk_valid),
      .blk_ready (blk_ready),
      .blk       (blk),
      .rsp_bus   (rsp_bus)
   );

endmodule
